@@ design/dht_pkg.sv @@
// ---------------------------------------------------------------------------
// dht_pkg - shared types and constants of the double hashing table
// Word layouts of the input and result channels, operation and status codes,
// register indexes and the request/response bundle of the remainder unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dht_pkg;

	// Key width and configuration register width.
	localparam int KEY_BITS = 31;
	localparam int CFG_W    = 7;
	localparam int CNT_W    = $clog2(KEY_BITS);
	localparam int IDX_W    = 1;

	// Operation codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOSLOT   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
	localparam logic [IDX_W-1:0] REG_STEP_PRIME = 1'd1;

	typedef struct packed {
		logic [1:0]          operation;
		logic [KEY_BITS-1:0] key;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] location;
		logic [6:0] occupancy;
	} out_word_t;

	// Remainder unit request: dividend bits are consumed from the top.
	typedef struct packed {
		logic                start;
		logic [KEY_BITS-1:0] dividend;
		logic [CFG_W-1:0]    divisor;
		logic [CNT_W-1:0]    last_bit;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [CFG_W-1:0] rem;
	} rem_rsp_t;

endpackage

@@ design/dht_rem_unit.sv @@
// ---------------------------------------------------------------------------
// dht_rem_unit - bit-serial remainder unit
// Restoring remainder of a dividend by a small divisor, one dividend bit per
// cycle, most significant bit first. Done pulses for one cycle at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dht_rem_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  dht_pkg::rem_req_t req,
	output dht_pkg::rem_rsp_t rsp
);
	import dht_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [KEY_BITS-1:0] div_q;
	logic [CFG_W-1:0]    rem_q;
	logic [CFG_W-1:0]    dvs_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [CFG_W:0]      trial;
	logic [CFG_W:0]      diff;
	logic [CFG_W-1:0]    rem_nxt;

	// One compare and subtract: the remainder stays below the divisor, so a
	// single conditional subtraction per bit is enough.
	always_comb begin
		trial   = {rem_q, div_q[KEY_BITS-1]};
		diff    = trial - {1'b0, dvs_q};
		rem_nxt = (trial >= {1'b0, dvs_q}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.dividend;
			dvs_q <= req.divisor;
			cnt_q <= req.last_bit;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[KEY_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ design/double_hash_table.sv @@
// ---------------------------------------------------------------------------
// double_hash_table - open addressing hash table with double hashing
// Insert, search, delete and clear of keys. Home slot is key mod size, the
// step is R - (key mod R) reduced mod size, and probes walk the table by it.
//
//   channel  direction  handshake                word
//   in       input      in_valid / in_ready      in_data   (operation, key)
//   out      output     out_valid / out_ready    out_data  (status, location,
//                                                           occupancy)
//   cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One word at a time. For insert, search and delete, two key remainders and a
// step remainder run through the one bit-serial unit (S_MODS, S_MODR, S_MODT),
// then each probe reads the key store in S_PROBE and checks the slot in
// S_CHECK, and the result is offered in S_OUT until it is taken.
// Clear and a rejected insert on a full table go straight to S_OUT.
// Reset empties the table at once; the key store itself is not cleared.
// A held result stalls the block; in_ready is low until it is taken.
// cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_hash_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  dht_pkg::in_word_t            in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output dht_pkg::out_word_t           out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dht_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dht_pkg::CFG_W-1:0]    cfg_data
);
	import dht_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CFG_W-1:0] SZ_CAP =
		(TABLE_DEPTH > 127) ? 7'd127 : CFG_W'(TABLE_DEPTH);

	// Sequencer codes.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MODS  = 3'd1;
	localparam logic [2:0] S_MODR  = 3'd2;
	localparam logic [2:0] S_MODT  = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_CHECK = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]             state_q;
	logic [CFG_W-1:0]       table_size_q;
	logic [CFG_W-1:0]       step_prime_q;
	logic [TABLE_DEPTH-1:0] used_q;
	logic [CW-1:0]          count_q;

	logic [1:0]             op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [CFG_W-1:0]       home_q;
	logic [CFG_W-1:0]       step_q;
	logic [CFG_W-1:0]       p_q;
	logic [CFG_W-1:0]       i_q;
	logic                   used_rd_q;
	logic [KEY_BITS-1:0]    key_rd_q;
	out_word_t              out_q;

	logic [KEY_BITS-1:0]    key_mem [TABLE_DEPTH];

	rem_req_t               rem_req;
	rem_rsp_t               rem_rsp;

	logic [CFG_W-1:0]       s_eff;
	logic [CFG_W-1:0]       r_eff;
	logic                   in_acc;
	logic                   full;
	logic [IW-1:0]          slot_idx;
	logic [CFG_W:0]         p_sum;
	logic [CFG_W:0]         p_wrap;
	logic [CFG_W-1:0]       p_next;
	logic [CFG_W-1:0]       r_diff;
	logic                   is_ins;
	logic                   key_hit;
	logic                   last_probe;
	logic                   finish;
	logic                   wr_ins;
	logic                   del_hit;
	logic [1:0]             chk_status;
	logic [CW-1:0]          count_d;

	// Effective size and prime: zero acts as one, size capped at the depth.
	always_comb begin
		if (table_size_q == '0) begin
			s_eff = 7'd1;
		end else if (32'(table_size_q) > TABLE_DEPTH) begin
			s_eff = SZ_CAP;
		end else begin
			s_eff = table_size_q;
		end
		r_eff = (step_prime_q == '0) ? 7'd1 : step_prime_q;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign full      = 32'(count_q) >= 32'(s_eff);
	assign slot_idx  = IW'(p_q);

	// Next probe slot: one add and a wrap by a single subtraction.
	always_comb begin
		p_sum  = {1'b0, p_q} + {1'b0, step_q};
		p_wrap = p_sum - {1'b0, s_eff};
		p_next = (p_sum >= {1'b0, s_eff}) ? p_wrap[CFG_W-1:0] : p_sum[CFG_W-1:0];
		r_diff = r_eff - rem_rsp.rem;
	end

	// Requests to the shared remainder unit.
	always_comb begin
		rem_req.start    = 1'b0;
		rem_req.dividend = in_data.key;
		rem_req.divisor  = s_eff;
		rem_req.last_bit = CNT_W'(KEY_BITS - 1);
		unique case (state_q)
			S_IDLE: begin
				rem_req.start = in_acc && (in_data.operation != OP_CLEAR)
					&& !((in_data.operation == OP_INSERT) && full);
			end
			S_MODS: begin
				rem_req.start    = rem_rsp.done;
				rem_req.dividend = key_q;
				rem_req.divisor  = r_eff;
			end
			S_MODR: begin
				rem_req.start    = rem_rsp.done;
				rem_req.dividend = {r_diff, {(KEY_BITS - CFG_W){1'b0}}};
				rem_req.last_bit = CNT_W'(CFG_W - 1);
			end
			S_MODT, S_PROBE, S_CHECK, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	dht_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Decision on a probed slot.
	always_comb begin
		is_ins     = (op_q == OP_INSERT);
		key_hit    = used_rd_q && (key_rd_q == key_q);
		last_probe = (i_q == s_eff - 7'd1);
		finish     = !used_rd_q || last_probe || (!is_ins && key_hit);
		wr_ins     = (state_q == S_CHECK) && is_ins && !used_rd_q;
		del_hit    = (state_q == S_CHECK) && (op_q == OP_DELETE) && key_hit;
		if (is_ins) begin
			chk_status = used_rd_q ? ST_NOSLOT : ST_OK;
		end else begin
			chk_status = key_hit ? ST_OK : ST_NOTFOUND;
		end
		count_d = count_q;
		if (wr_ins) begin
			count_d = count_q + 1'b1;
		end else if (del_hit && count_q != '0) begin
			count_d = count_q - 1'b1;
		end
	end

	// Sequencer, registers, slot flags and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			table_size_q <= 7'd64;
			step_prime_q <= 7'd61;
			used_q       <= '0;
			count_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_TABLE_SIZE: table_size_q <= cfg_data;
					REG_STEP_PRIME: step_prime_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.operation == OP_CLEAR) begin
							used_q  <= '0;
							count_q <= '0;
							state_q <= S_OUT;
						end else if ((in_data.operation == OP_INSERT) && full) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_MODS;
						end
					end
				end
				S_MODS: if (rem_rsp.done) state_q <= S_MODR;
				S_MODR: if (rem_rsp.done) state_q <= S_MODT;
				S_MODT: if (rem_rsp.done) state_q <= S_PROBE;
				S_PROBE: state_q <= S_CHECK;
				S_CHECK: begin
					count_q <= count_d;
					if (wr_ins) used_q[slot_idx] <= 1'b1;
					if (del_hit) used_q[slot_idx] <= 1'b0;
					state_q <= finish ? S_OUT : S_PROBE;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operand, probe and result registers.
	always_ff @(posedge clk) begin
		used_rd_q <= used_q[slot_idx];
		if (in_acc) begin
			op_q  <= in_data.operation;
			key_q <= in_data.key;
			out_q.location  <= '0;
			out_q.occupancy <= (in_data.operation == OP_CLEAR) ? 7'd0 : 7'(count_q);
			out_q.status    <= (in_data.operation == OP_CLEAR) ? ST_OK : ST_FULL;
		end
		if (state_q == S_MODS && rem_rsp.done) begin
			home_q <= rem_rsp.rem;
		end
		if (state_q == S_MODT && rem_rsp.done) begin
			p_q    <= home_q;
			step_q <= rem_rsp.rem;
			i_q    <= '0;
		end
		if (state_q == S_CHECK) begin
			p_q <= p_next;
			i_q <= i_q + 7'd1;
			if (finish) begin
				out_q.status    <= chk_status;
				out_q.location  <= (chk_status == ST_OK) ? 6'(p_q) : 6'd0;
				out_q.occupancy <= 7'(count_d);
			end
		end
	end

	// Key store: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_ins) begin
			key_mem[slot_idx] <= key_q;
		end
		key_rd_q <= key_mem[slot_idx];
	end

endmodule

@@ design/dht_checker.sv @@
// ---------------------------------------------------------------------------
// dht_checker - port level checks of the double hashing table
// Watches the channels of the top level and flags behaviour that the
// one-word-at-a-time sequencer must never show.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dht_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input dht_pkg::out_word_t out_data
);
	import dht_pkg::*;

	// The block never takes a word while a result is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is held");

	// After a word is taken the block stops taking words.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word taken straight after the first");

	// A failing status reports slot zero.
	a_fail_loc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> (out_data.location == 6'd0))
		else $error("failing result with a nonzero location");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind double_hash_table dht_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dht_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - self-checking bench for the double hashing table
// Drives insert, search, delete and clear words through the in channel and
// checks every result word against a table model kept in the bench or a planned
// answer. A short planned sequence covers the edge cases. Random phases follow,
// each with its own size and step prime, run under bursty input and a stalling output.
// ---------------------------------------------------------------------------

module testbench;

	import dht_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int RANDOM_WORDS = 1575;
	localparam int SLOTS       = 64;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e        kind;
		in_word_t         word;
		logic             typed;
		out_word_t        want;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	in_word_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_word_t          out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	// Model of the table: keys, occupied flags, count and register copies.
	logic [KEY_BITS-1:0] slot_key [SLOTS];
	logic [SLOTS-1:0]    slot_taken;
	int unsigned         live_count;
	logic [CFG_W-1:0]    cfg_size;
	logic [CFG_W-1:0]    cfg_prime;

	out_word_t           answer_q [$];
	plan_row_t           plan_q [$];
	logic [KEY_BITS-1:0] key_pool [$];

	int unsigned errors;
	int unsigned stalled_cycles;
	int unsigned burst_left;
	int unsigned rush_left;
	logic        hold_req;
	out_word_t   head_answer;

	double_hash_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Error log: the first ten are printed, the rest only counted.
	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	// ------------------------------------------------------------------
	// Table model
	// ------------------------------------------------------------------

	function automatic int unsigned live_size();
		if (cfg_size == '0)
			return 1;
		if (32'(cfg_size) > SLOTS)
			return SLOTS;
		return 32'(cfg_size);
	endfunction

	// Slot visited by probe i of a key in a table of s slots.
	function automatic int unsigned probe_slot(input logic [KEY_BITS-1:0] key,
			input int unsigned i, input int unsigned s);
		int unsigned r;
		int unsigned home;
		int unsigned stride;
		r = (cfg_prime == '0) ? 1 : 32'(cfg_prime);
		home = 32'(key) % s;
		stride = (r - 32'(key) % r) % s;
		return (home + i * stride) % s;
	endfunction

	// Walks the probe sequence and stops at the matching key or at the first free slot.
	function automatic bit locate_key(input logic [KEY_BITS-1:0] key,
			output int unsigned slot);
		int unsigned s;
		int unsigned p;
		s = live_size();
		slot = 0;
		for (int unsigned i = 0; i < s; i++) begin
			p = probe_slot(key, i, s);
			if (!slot_taken[p])
				return 1'b0;
			if (slot_key[p] == key) begin
				slot = p;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Applies one word to the model and returns the answer it should give.
	function automatic out_word_t table_apply(input in_word_t w);
		out_word_t   res;
		int unsigned s;
		int unsigned p;
		bit          placed;
		s = live_size();
		res.status = ST_OK;
		res.location = '0;
		placed = 1'b0;
		case (w.operation)
			OP_INSERT: begin
				if (live_count >= s) begin
					res.status = ST_FULL;
				end else begin
					for (int unsigned i = 0; i < s && !placed; i++) begin
						p = probe_slot(w.key, i, s);
						if (!slot_taken[p]) begin
							placed = 1'b1;
							slot_key[p] = w.key;
							slot_taken[p] = 1'b1;
							live_count++;
							res.location = p[5:0];
						end
					end
					if (!placed)
						res.status = ST_NOSLOT;
				end
			end
			OP_SEARCH: begin
				if (locate_key(w.key, p))
					res.location = p[5:0];
				else
					res.status = ST_NOTFOUND;
			end
			OP_DELETE: begin
				if (locate_key(w.key, p)) begin
					slot_taken[p] = 1'b0;
					if (live_count > 0)
						live_count--;
					res.location = p[5:0];
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			default: begin
				slot_taken = '0;
				live_count = 0;
			end
		endcase
		res.occupancy = live_count[6:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offers one word and records its answer once the block takes it.
	task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
		out_word_t predicted;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = table_apply(w);
		answer_q.push_back(typed ? want : predicted);
	endtask

	// Lowers valid and waits until every outstanding answer has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_TABLE_SIZE)
			cfg_size = val;
		else
			cfg_prime = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Bursts of back-to-back words separated by idle gaps; now and then the
	// sender waits for the table to go quiet.
	task automatic pace();
		int unsigned gap;
		if (rush_left > 0) begin
			rush_left--;
			return;
		end
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			: $urandom_range(0, 8);
		if ($urandom_range(0, 30) == 0) begin
			drain();
		end else begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic plan_word(input logic [1:0] op, input logic [KEY_BITS-1:0] key);
		plan_row_t r;
		r.kind = ROW_WORD;
		r.word.operation = op;
		r.word.key = key;
		r.typed = 1'b0;
		r.want = '0;
		r.idx = '0;
		r.val = '0;
		plan_q.push_back(r);
	endtask

	task automatic plan_checked(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
			input logic [1:0] st, input logic [5:0] loc, input logic [6:0] occ);
		plan_row_t r;
		r.kind = ROW_WORD;
		r.word.operation = op;
		r.word.key = key;
		r.typed = 1'b1;
		r.want.status = st;
		r.want.location = loc;
		r.want.occupancy = occ;
		r.idx = '0;
		r.val = '0;
		plan_q.push_back(r);
	endtask

	task automatic plan_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		plan_row_t r;
		r.kind = ROW_REG;
		r.word = '0;
		r.typed = 1'b0;
		r.want = '0;
		r.idx = idx;
		r.val = val;
		plan_q.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Receiver: changing stall patterns, plus a long hold on request.
	// ------------------------------------------------------------------
	initial begin
		int unsigned hold_left;
		int unsigned mode;
		int unsigned mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result check against the oldest outstanding answer.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (answer_q.size() == 0) begin
				note_error($sformatf("unexpected word: status %0d location %0d occupancy %0d",
					out_data.status, out_data.location, out_data.occupancy));
			end else begin
				head_answer = answer_q.pop_front();
				if (head_answer.status != out_data.status ||
						head_answer.location != out_data.location ||
						head_answer.occupancy != out_data.occupancy) begin
					note_error($sformatf({"mismatch: expected status %0d location %0d ",
						"occupancy %0d, got status %0d location %0d occupancy %0d"},
						head_answer.status, head_answer.location, head_answer.occupancy,
						out_data.status, out_data.location, out_data.occupancy));
				end
			end
		end
	end

	// Watchdog: ends the run when no channel has moved a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned    sent;
		int unsigned    phase;
		int unsigned    phase_words;
		int unsigned    pick;
		int unsigned    pool_size;
		logic [CFG_W-1:0] next_size;
		logic [CFG_W-1:0] next_prime;
		in_word_t       w;
		plan_row_t      r;
		logic [KEY_BITS-1:0] full_key;
		int unsigned    primes [18];

		primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		errors = 0;
		stalled_cycles = 0;
		burst_left = 0;
		rush_left = 0;
		for (int i = 0; i < SLOTS; i++)
			slot_key[i] = '0;
		slot_taken = '0;
		live_count = 0;
		cfg_size = 7'd64;
		cfg_prime = 7'd61;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Planned sequence: empty table, extreme keys, the freed slot that
		// hides a later key, a step of zero, a full table, a shrunk table and
		// the register extremes.
		plan_checked(OP_SEARCH, 31'd5, ST_NOTFOUND, 6'd0, 7'd0);
		plan_checked(OP_DELETE, 31'd5, ST_NOTFOUND, 6'd0, 7'd0);
		plan_checked(OP_CLEAR, '1, ST_OK, 6'd0, 7'd0);
		plan_checked(OP_INSERT, 31'd0, ST_OK, 6'd0, 7'd1);
		plan_checked(OP_INSERT, 31'h7FFFFFFF, ST_OK, 6'd63, 7'd2);
		plan_checked(OP_SEARCH, 31'h7FFFFFFF, ST_OK, 6'd63, 7'd2);
		plan_word(OP_INSERT, 31'd64);
		plan_word(OP_INSERT, 31'd128);
		plan_word(OP_SEARCH, 31'd64);
		plan_checked(OP_DELETE, 31'd0, ST_OK, 6'd0, 7'd3);
		plan_checked(OP_SEARCH, 31'd64, ST_NOTFOUND, 6'd0, 7'd3);
		plan_word(OP_INSERT, 31'h2AAAAAAA);
		plan_word(OP_INSERT, 31'h55555555);
		plan_word(OP_DELETE, 31'h2AAAAAAA);
		plan_checked(OP_CLEAR, 31'd0, ST_OK, 6'd0, 7'd0);
		plan_reg(REG_TABLE_SIZE, 7'd2);
		plan_checked(OP_INSERT, 31'd7, ST_OK, 6'd1, 7'd1);
		plan_checked(OP_INSERT, 31'd9, ST_NOSLOT, 6'd0, 7'd1);
		plan_checked(OP_INSERT, 31'd4, ST_OK, 6'd0, 7'd2);
		plan_checked(OP_INSERT, 31'd11, ST_FULL, 6'd0, 7'd2);
		plan_reg(REG_TABLE_SIZE, 7'd0);
		plan_checked(OP_INSERT, 31'd5, ST_FULL, 6'd0, 7'd2);
		plan_word(OP_SEARCH, 31'd4);
		plan_reg(REG_TABLE_SIZE, 7'd127);
		plan_reg(REG_STEP_PRIME, 7'd0);
		plan_word(OP_INSERT, 31'd64);
		plan_word(OP_SEARCH, 31'd7);
		plan_reg(REG_STEP_PRIME, 7'd127);
		plan_word(OP_SEARCH, 31'd64);
		plan_checked(OP_CLEAR, 31'd0, ST_OK, 6'd0, 7'd0);

		foreach (plan_q[i]) begin
			r = plan_q[i];
			if (r.kind == ROW_REG) begin
				write_reg(r.idx, r.val);
			end else begin
				send_word(r.word, r.typed, r.want);
				pace();
			end
		end

		// Random phases, each with its own size and step prime.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				next_size = CFG_W'($urandom_range(1, 12));
			else if (pick < 85)
				next_size = CFG_W'($urandom_range(13, 64));
			else if (pick < 92)
				next_size = 7'd0;
			else
				next_size = CFG_W'($urandom_range(65, 127));
			if ($urandom_range(0, 9) < 6)
				next_prime = CFG_W'(primes[$urandom_range(0, 17)]);
			else
				next_prime = CFG_W'($urandom_range(0, 127));
			write_reg(REG_TABLE_SIZE, next_size);
			write_reg(REG_STEP_PRIME, next_prime);

			// Keys of this phase: some small, some across the full width.
			key_pool.delete();
			pool_size = $urandom_range(4, 14);
			for (int unsigned k = 0; k < pool_size; k++) begin
				full_key = KEY_BITS'($urandom);
				key_pool.push_back(($urandom_range(0, 1) == 0) ? full_key
					: KEY_BITS'($urandom_range(0, 300)));
			end

			// Early on, hold the receiver while words keep coming, so a result is
			// held and the block stalls its input.
			if (phase == 1) begin
				hold_req = 1'b1;
				rush_left = 10;
			end

			// Phases start empty at even odds; the others keep what the last size left.
			if ($urandom_range(0, 1) == 0) begin
				w.operation = OP_CLEAR;
				w.key = KEY_BITS'($urandom);
				send_word(w, 1'b0, '0);
				sent++;
				pace();
			end

			phase_words = $urandom_range(30, 90);
			for (int unsigned n = 0; n < phase_words; n++) begin
				pick = $urandom_range(0, 99);
				w.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				if (pick < 45) begin
					w.operation = OP_INSERT;
				end else if (pick < 70) begin
					w.operation = OP_SEARCH;
				end else if (pick < 92) begin
					w.operation = OP_DELETE;
				end else if (pick < 94) begin
					w.operation = OP_CLEAR;
				end else begin
					// Noise: any operation on any key.
					w.operation = 2'($urandom_range(0, 3));
					w.key = KEY_BITS'($urandom);
				end
				send_word(w, 1'b0, '0);
				sent++;
				pace();
			end
			phase++;
		end

		// Wait for the last answers, then give stray words time to show.
		drain();
		repeat (250) @(posedge clk);
		if (answer_q.size() != 0)
			note_error($sformatf("%0d answers never arrived", answer_q.size()));

		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ files.f @@
design/dht_pkg.sv
design/dht_rem_unit.sv
design/double_hash_table.sv
design/dht_checker.sv
test/testbench.sv
